@@ hdl/pcvf_pkg.sv @@
// Shared constants for the per-channel velocity fatigue block.
// Used by the top level and the port checker; no dependencies.
package pcvf_pkg;

  localparam int NumInstrumentsDefault = 64;
  localparam int PositionBitsDefault   = 48;

  // Q1.15 unity
  localparam logic [15:0] UNITY = 16'd32768;

  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 32;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_FATIGUE_ENABLE = 2'd0,
    REG_RECOVERY_RATE  = 2'd1,
    REG_FATIGUE_WEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic        RESET_FATIGUE_ENABLE = 1'b1;
  localparam logic [31:0] RESET_RECOVERY_RATE  = 32'd65536;
  localparam logic [15:0] RESET_FATIGUE_WEIGHT = 16'd32768;

endpackage

@@ hdl/pcvf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency; sized by WIDTH and DEPTH.
module pcvf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/per_channel_velocity_fatigue.sv @@
// A result appears after the read, recovery multiply, add and scale steps with fatigue
// on, and after the read and scale steps with it off or for an instrument beyond the
// table. One item in flight: no new input is taken until the result is registered.
// A result waiting on the output does not block the next input transfer.
// Reset (rst, synchronous): config registers return to defaults, then a clearing pass
// over all NUM_INSTRUMENTS entries zeroes the valid RAM; no input is taken during it.
module per_channel_velocity_fatigue
  #(
  parameter int NUM_INSTRUMENTS = pcvf_pkg::NumInstrumentsDefault,
  parameter int POSITION_BITS   = pcvf_pkg::PositionBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcvf_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [pcvf_pkg::CfgDataBits-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [5:0]                       instrument,
  input  logic [POSITION_BITS-1:0]         position,
  input  logic [15:0]                      velocity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      scaled_velocity,
  output logic [15:0]                      current_modifier
);
  import pcvf_pkg::*;

  localparam int AW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int SW = 16 + POSITION_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_MUL1, S_REC, S_MUL2
  } state_t;

  state_t state;

  // configuration
  logic        fatigue_enable;
  logic [31:0] recovery_rate;
  logic [15:0] fatigue_weight;

  // item registers
  logic [AW-1:0]            addr;
  logic                     out_of_range;
  logic [POSITION_BITS-1:0] pos;
  logic [15:0]              vel;
  logic                     bypass;
  logic [15:0]              mult0;
  logic                     sat;
  logic [30:0]              elapsed_lo;
  logic [14:0]              inc;
  logic [15:0]              mult;
  logic [AW-1:0]            clr_addr;

  // RAM hookups
  logic          st_we;
  logic [SW-1:0] st_wdata;
  logic [SW-1:0] st_rdata;
  logic          vl_we;
  logic [AW-1:0] vl_waddr;
  logic          vl_wdata;
  logic          vl_rdata;
  logic          in_xfer;
  logic [AW-1:0] in_addr;

  // combinational datapath
  logic [15:0]              ram_mult;
  logic [POSITION_BITS-1:0] ram_pos;
  logic [POSITION_BITS-1:0] elapsed;
  logic [63:0]              elapsed_ext;
  logic [62:0]              rec_prod;
  logic [16:0]              rec_sum;
  logic [15:0]              rec_mult;
  logic [31:0]              vel_prod;
  logic [31:0]              wgt_prod;
  logic [16:0]              wgt_q;
  logic [15:0]              next_mult;
  logic                     out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign in_addr   = AW'(instrument);
  assign out_free  = !out_valid || out_ready;

  assign ram_mult    = vl_rdata ? st_rdata[SW-1 -: 16] : UNITY;
  assign ram_pos     = vl_rdata ? st_rdata[POSITION_BITS-1:0] : '0;
  assign elapsed     = pos - ram_pos;
  assign elapsed_ext = 64'(elapsed);
  assign rec_prod    = 63'(elapsed_lo) * 63'(recovery_rate);
  assign rec_sum     = {2'b00, inc} + {1'b0, mult0};
  assign rec_mult    = (sat || rec_sum > 17'(UNITY)) ? UNITY : rec_sum[15:0];
  assign vel_prod    = 32'(vel) * 32'(mult);
  assign wgt_prod    = 32'(mult) * 32'(fatigue_weight);
  assign wgt_q       = wgt_prod[31:15];
  assign next_mult   = (wgt_q > 17'(UNITY)) ? UNITY : wgt_q[15:0];

  assign st_we    = (state == S_MUL2) && out_free && !out_of_range;
  assign st_wdata = bypass ? {UNITY, {POSITION_BITS{1'b0}}} : {next_mult, pos};
  assign vl_we    = (state == S_CLEAR) || st_we;
  assign vl_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign vl_wdata = (state != S_CLEAR);

  pcvf_ram #(.WIDTH(SW), .DEPTH(NUM_INSTRUMENTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (addr),
    .wdata (st_wdata),
    .re    (in_xfer),
    .raddr (in_addr),
    .rdata (st_rdata)
  );

  pcvf_ram #(.WIDTH(1), .DEPTH(NUM_INSTRUMENTS)) u_valid_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (vl_wdata),
    .re    (in_xfer),
    .raddr (in_addr),
    .rdata (vl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fatigue_enable <= RESET_FATIGUE_ENABLE;
      recovery_rate  <= RESET_RECOVERY_RATE;
      fatigue_weight <= RESET_FATIGUE_WEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FATIGUE_ENABLE: fatigue_enable <= cfg_data[0];
        REG_RECOVERY_RATE:  recovery_rate  <= cfg_data;
        REG_FATIGUE_WEIGHT: fatigue_weight <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_MUL2 handles its own output transfer
      if (out_valid && out_ready && state != S_MUL2) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_INSTRUMENTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            addr         <= in_addr;
            out_of_range <= 32'(instrument) >= 32'(NUM_INSTRUMENTS);
            pos          <= position;
            vel          <= velocity;
            state        <= S_READ;
          end
        end
        S_READ: begin
          bypass     <= out_of_range || !fatigue_enable;
          mult0      <= ram_mult;
          // any elapsed count of 2^31 or more saturates once the rate is nonzero
          sat        <= (|elapsed_ext[63:31]) && (recovery_rate != 32'd0);
          elapsed_lo <= elapsed_ext[30:0];
          state      <= (out_of_range || !fatigue_enable) ? S_MUL2 : S_MUL1;
        end
        S_MUL1: begin
          sat   <= sat || (|rec_prod[62:31]);
          inc   <= rec_prod[30:16];
          state <= S_REC;
        end
        S_REC: begin
          mult  <= rec_mult;
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            scaled_velocity  <= bypass ? vel : vel_prod[30:15];
            current_modifier <= bypass ? UNITY : next_mult;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/pcvf_checker.sv @@
// Port-level checks for the per-channel velocity fatigue block, bound to the top.
// Depends on pcvf_pkg for the unity constant and the config port widths.
module pcvf_checker #(
  parameter int POSITION_BITS = pcvf_pkg::PositionBitsDefault
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [pcvf_pkg::CfgIndexBits-1:0] cfg_index,
  input logic [pcvf_pkg::CfgDataBits-1:0]  cfg_data,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [5:0]                       instrument,
  input logic [POSITION_BITS-1:0]         position,
  input logic [15:0]                      velocity,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [15:0]                      scaled_velocity,
  input logic [15:0]                      current_modifier
);
  import pcvf_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scaled_velocity)
      && $stable(current_modifier))
    else $error("result changed while stalled");

  // one item in flight: no second transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_modifier_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_modifier <= UNITY)
    else $error("modifier above unity");

  a_cfg_always: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind per_channel_velocity_fatigue pcvf_checker #(.POSITION_BITS(POSITION_BITS)) u_checker (
  .clk              (clk),
  .rst              (rst),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready),
  .cfg_index        (cfg_index),
  .cfg_data         (cfg_data),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .instrument       (instrument),
  .position         (position),
  .velocity         (velocity),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .scaled_velocity  (scaled_velocity),
  .current_modifier (current_modifier)
);
